// File: hdl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Types, widths and constants shared by the cubic Bezier evaluator pipeline.
// ----------------------------------------------------------------------------
package cbe_pkg;

    // field widths
    localparam int CoordW  = 32;
    localparam int TW      = 17;
    localparam int NumPts  = 4;

    // stream payload widths
    localparam int SDataW  = 280;
    localparam int SUserW  = 2;
    localparam int MDataW  = 64;
    localparam int MUserW  = 1;

    // weight and accumulator widths
    localparam int WeightW = 50;
    localparam int WLoW    = 25;
    localparam int WHiW    = WeightW - WLoW;
    localparam int ProdLoW = WLoW + 1 + CoordW;
    localparam int ProdHiW = WHiW + CoordW;
    localparam int SumLoW  = ProdLoW + 2;
    localparam int SumHiW  = ProdHiW + 2;
    localparam int AccW    = 88;

    // products of the curve parameter
    localparam int SqW     = 33;
    localparam int CubeW   = 50;

    // stages from request accept to result register
    localparam int PipeDepth = 7;

    localparam logic [TW-1:0] OneQ16 = 17'h10000;

    typedef logic signed [CoordW-1:0]  coord_t;
    typedef logic signed [WeightW-1:0] weight_t;
    typedef logic        [TW-1:0]      tparam_t;
    typedef logic        [SqW-1:0]     square_t;
    typedef logic signed [AccW-1:0]    acc_t;

    typedef enum logic [1:0] {
        OP_POS  = 2'd0,
        OP_VEL  = 2'd1,
        OP_ACC  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    // power of two that the weighted sum still has to be scaled by
    typedef enum logic [1:0] {
        SCALE_0  = 2'd0,
        SCALE_16 = 2'd1,
        SCALE_32 = 2'd2
    } scale_t;

    typedef struct packed {
        logic   adv;
        scale_t scale;
    } dot_ctl_t;

    // rounding offsets and final shifts, one pair per scale
    localparam acc_t RndS0  = AccW'(1) << 47;
    localparam acc_t RndS16 = AccW'(1) << 31;
    localparam acc_t RndS32 = AccW'(1) << 15;
    localparam int   ShfS0  = 48;
    localparam int   ShfS16 = 32;
    localparam int   ShfS32 = 16;

    // saturation bounds
    localparam acc_t   SatMax   = {{(AccW - CoordW + 1){1'b0}}, {(CoordW - 1){1'b1}}};
    localparam acc_t   SatMin   = {{(AccW - CoordW + 1){1'b1}}, {(CoordW - 1){1'b0}}};
    localparam coord_t CoordMax = {1'b0, {(CoordW - 1){1'b1}}};
    localparam coord_t CoordMin = {1'b1, {(CoordW - 1){1'b0}}};

    function automatic weight_t times3(weight_t v);
        return v + (v <<< 1);
    endfunction

    function automatic weight_t times6(weight_t v);
        return times3(v) <<< 1;
    endfunction

endpackage

// File: hdl/cbe_dot.sv
// ----------------------------------------------------------------------------
// cbe_dot
// Four-stage weighted sum of one coordinate: split products, partial sums,
// merge with rounding offset, then final shift and saturation.
// ----------------------------------------------------------------------------
module cbe_dot (
    input  logic              aclk,
    input  cbe_pkg::dot_ctl_t ctl_i,
    input  cbe_pkg::weight_t  w_i [cbe_pkg::NumPts],
    input  cbe_pkg::coord_t   p_i [cbe_pkg::NumPts],
    output cbe_pkg::coord_t   value_o,
    output logic              sat_o
);
    import cbe_pkg::*;

    logic signed [ProdLoW-1:0] prod_lo_reg [NumPts];
    logic signed [ProdHiW-1:0] prod_hi_reg [NumPts];
    logic signed [ProdLoW-1:0] prod_lo_next [NumPts];
    logic signed [ProdHiW-1:0] prod_hi_next [NumPts];
    scale_t                    d1_scale_reg;

    logic signed [SumLoW-1:0]  sum_lo_reg, sum_lo_next;
    logic signed [SumHiW-1:0]  sum_hi_reg, sum_hi_next;
    scale_t                    d2_scale_reg;

    acc_t                      acc_reg, acc_next;
    scale_t                    d3_scale_reg;

    acc_t                      shifted;
    coord_t                    value_reg, value_next;
    logic                      sat_reg, sat_next;

    // weight split into unsigned low and signed high halves
    always_comb begin
        for (int i = 0; i < NumPts; i++) begin
            prod_lo_next[i] = $signed({1'b0, w_i[i][WLoW-1:0]}) * p_i[i];
            prod_hi_next[i] = $signed(w_i[i][WeightW-1:WLoW]) * p_i[i];
        end
    end

    // partial sums over the four control points
    always_comb begin
        sum_lo_next = SumLoW'(prod_lo_reg[0]) + SumLoW'(prod_lo_reg[1])
                    + SumLoW'(prod_lo_reg[2]) + SumLoW'(prod_lo_reg[3]);
        sum_hi_next = SumHiW'(prod_hi_reg[0]) + SumHiW'(prod_hi_reg[1])
                    + SumHiW'(prod_hi_reg[2]) + SumHiW'(prod_hi_reg[3]);
    end

    // merge halves and add rounding offset for this scale
    always_comb begin
        case (d2_scale_reg)
            SCALE_16: acc_next = (AccW'(sum_hi_reg) <<< WLoW) + AccW'(sum_lo_reg) + RndS16;
            SCALE_32: acc_next = (AccW'(sum_hi_reg) <<< WLoW) + AccW'(sum_lo_reg) + RndS32;
            default:  acc_next = (AccW'(sum_hi_reg) <<< WLoW) + AccW'(sum_lo_reg) + RndS0;
        endcase
    end

    // final shift and saturation
    always_comb begin
        case (d3_scale_reg)
            SCALE_16: shifted = acc_reg >>> ShfS16;
            SCALE_32: shifted = acc_reg >>> ShfS32;
            default:  shifted = acc_reg >>> ShfS0;
        endcase
        if (shifted > SatMax) begin
            value_next = CoordMax;
            sat_next   = 1'b1;
        end else if (shifted < SatMin) begin
            value_next = CoordMin;
            sat_next   = 1'b1;
        end else begin
            value_next = shifted[CoordW-1:0];
            sat_next   = 1'b0;
        end
    end

    // datapath registers, held while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (ctl_i.adv) begin
            for (int i = 0; i < NumPts; i++) begin
                prod_lo_reg[i] <= prod_lo_next[i];
                prod_hi_reg[i] <= prod_hi_next[i];
            end
            d1_scale_reg <= ctl_i.scale;
            sum_lo_reg   <= sum_lo_next;
            sum_hi_reg   <= sum_hi_next;
            d2_scale_reg <= d1_scale_reg;
            acc_reg      <= acc_next;
            d3_scale_reg <= d2_scale_reg;
            value_reg    <= value_next;
            sat_reg      <= sat_next;
        end
    end

    assign value_o = value_reg;
    assign sat_o   = sat_reg;

endmodule

// File: hdl/cubic_bezier_evaluator_core.sv
// seven register stages from request accept to m_tvalid
// throughput: one request per cycle while m_tready stays high
// a stalled result holds the whole pipeline; s_tready follows m_tready while a result waits
// reset: aresetn (synchronous, active low) clears all stage valid bits, s_tready low in reset
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator_core
// Streams cubic Bezier position, first or second derivative per request,
// Q16.16 coordinates, rounded and saturated.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
    // param_t, zero fill
    input  logic [cbe_pkg::SDataW-1:0] s_tdata,
    // opcode
    input  logic [cbe_pkg::SUserW-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_x, out_y
    output logic [cbe_pkg::MDataW-1:0] m_tdata,
    // overflow
    output logic [cbe_pkg::MUserW-1:0] m_tuser
);
    import cbe_pkg::*;

    logic                 adv;
    logic [PipeDepth-1:0] valid_reg, valid_next;

    // stage 1: clamp t, form u
    tparam_t t_clamp;
    tparam_t t1_t_reg, t1_u_reg;
    opcode_t t1_op_reg;
    coord_t  t1_x_reg [NumPts];
    coord_t  t1_y_reg [NumPts];

    // stage 2: squares and cross term
    logic [2*TW-1:0] uu_full, ut_full, tt_full;
    tparam_t t2_t_reg, t2_u_reg;
    square_t t2_uu_reg, t2_ut_reg, t2_tt_reg;
    opcode_t t2_op_reg;
    coord_t  t2_x_reg [NumPts];
    coord_t  t2_y_reg [NumPts];

    // stage 3: cubes and weight selection
    logic [CubeW-1:0] p_uuu, p_uut, p_utt, p_ttt;
    weight_t e_u, e_t, e_uu, e_ut, e_tt;
    weight_t w_next [NumPts];
    weight_t t3_w_reg [NumPts];
    scale_t  scale_next, t3_scale_reg;
    coord_t  t3_x_reg [NumPts];
    coord_t  t3_y_reg [NumPts];

    dot_ctl_t dot_ctl;
    coord_t   out_x, out_y;
    logic     sat_x, sat_y;

    // global advance: move when the result register is free or drained
    assign adv      = !valid_reg[PipeDepth-1] || m_tready;
    assign s_tready = adv & aresetn;
    assign m_tvalid = valid_reg[PipeDepth-1];

    assign valid_next = {valid_reg[PipeDepth-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    assign t_clamp = (s_tdata[NumPts*2*CoordW +: TW] > OneQ16)
                   ? OneQ16 : s_tdata[NumPts*2*CoordW +: TW];

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_t_reg  <= t_clamp;
            t1_u_reg  <= OneQ16 - t_clamp;
            t1_op_reg <= opcode_t'(s_tuser[1:0]);
            for (int i = 0; i < NumPts; i++) begin
                t1_x_reg[i] <= s_tdata[2*i*CoordW +: CoordW];
                t1_y_reg[i] <= s_tdata[(2*i+1)*CoordW +: CoordW];
            end
        end
    end

    assign uu_full = {{TW{1'b0}}, t1_u_reg} * {{TW{1'b0}}, t1_u_reg};
    assign ut_full = {{TW{1'b0}}, t1_u_reg} * {{TW{1'b0}}, t1_t_reg};
    assign tt_full = {{TW{1'b0}}, t1_t_reg} * {{TW{1'b0}}, t1_t_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            t2_t_reg  <= t1_t_reg;
            t2_u_reg  <= t1_u_reg;
            t2_uu_reg <= uu_full[SqW-1:0];
            t2_ut_reg <= ut_full[SqW-1:0];
            t2_tt_reg <= tt_full[SqW-1:0];
            t2_op_reg <= t1_op_reg;
            t2_x_reg  <= t1_x_reg;
            t2_y_reg  <= t1_y_reg;
        end
    end

    // cubic terms of the position weights
    assign p_uuu = CubeW'(t2_u_reg) * CubeW'(t2_uu_reg);
    assign p_uut = CubeW'(t2_t_reg) * CubeW'(t2_uu_reg);
    assign p_utt = CubeW'(t2_u_reg) * CubeW'(t2_tt_reg);
    assign p_ttt = CubeW'(t2_t_reg) * CubeW'(t2_tt_reg);

    assign e_u  = WeightW'(t2_u_reg);
    assign e_t  = WeightW'(t2_t_reg);
    assign e_uu = WeightW'(t2_uu_reg);
    assign e_ut = WeightW'(t2_ut_reg);
    assign e_tt = WeightW'(t2_tt_reg);

    // Bernstein weights per opcode, before the remaining power-of-two scale
    always_comb begin
        case (t2_op_reg)
            OP_POS: begin
                w_next[0]  = weight_t'(p_uuu);
                w_next[1]  = times3(weight_t'(p_uut));
                w_next[2]  = times3(weight_t'(p_utt));
                w_next[3]  = weight_t'(p_ttt);
                scale_next = SCALE_0;
            end
            OP_VEL: begin
                w_next[0]  = -times3(e_uu);
                w_next[1]  = times3(e_uu - (e_ut <<< 1));
                w_next[2]  = times3((e_ut <<< 1) - e_tt);
                w_next[3]  = times3(e_tt);
                scale_next = SCALE_16;
            end
            OP_ACC: begin
                w_next[0]  = times6(e_u);
                w_next[1]  = times6(e_t - (e_u <<< 1));
                w_next[2]  = times6(e_u - (e_t <<< 1));
                w_next[3]  = times6(e_t);
                scale_next = SCALE_32;
            end
            default: begin
                // unused opcode: zero weights round to a zero result
                for (int i = 0; i < NumPts; i++) begin
                    w_next[i] = '0;
                end
                scale_next = SCALE_0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t3_w_reg     <= w_next;
            t3_scale_reg <= scale_next;
            t3_x_reg     <= t2_x_reg;
            t3_y_reg     <= t2_y_reg;
        end
    end

    assign dot_ctl.adv   = adv;
    assign dot_ctl.scale = t3_scale_reg;

    cbe_dot u_dot_x (
        .aclk    (aclk),
        .ctl_i   (dot_ctl),
        .w_i     (t3_w_reg),
        .p_i     (t3_x_reg),
        .value_o (out_x),
        .sat_o   (sat_x)
    );

    cbe_dot u_dot_y (
        .aclk    (aclk),
        .ctl_i   (dot_ctl),
        .w_i     (t3_w_reg),
        .p_i     (t3_y_reg),
        .value_o (out_y),
        .sat_o   (sat_y)
    );

    assign m_tdata    = {out_y, out_x};
    assign m_tuser[0] = sat_x | sat_y;

endmodule
